// File: hdl/atq_pkg.sv
package atq_pkg;

  // Default geometry: ROM entries per turn and fraction bits per entry.
  localparam int TABLE_SIZE_DEF = 512;
  localparam int FRAC_SHIFT_DEF = 6;

  localparam int COORD_W = 16;
  localparam int SIN_W   = 16;
  localparam int MAG_W   = 17;
  localparam int PROD_W  = 32;
  localparam int D_W     = 33;
  localparam int R_W     = 35;
  localparam int ANGLE_W = 15;

  localparam logic signed [SIN_W-1:0] SIN_MAX     = 16'sh7FFF;
  localparam logic [MAG_W-1:0]        MAG_SAT     = 17'd32767;
  localparam logic [ANGLE_W-1:0]      ANG_QUARTER = 15'h2000;
  localparam logic [ANGLE_W-1:0]      ANG_THREE_Q = 15'h6000;

  // 2*pi in Q60 and one half in Q30, used only while the sine table is built.
  localparam longint unsigned TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam longint unsigned HALF_Q30   = 64'd1 << 29;
  localparam longint unsigned HALF_Q15   = 64'd1 << 14;

  localparam int TAYLOR_TERMS = 12;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Sine of t (Q30 radians, first quadrant) in Q30, by a Taylor series.
  function automatic longint unsigned sin_q30(input longint unsigned t);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    x2   = (t * t + HALF_Q30) >> 30;
    term = t;
    acc  = t;
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      term = (term * x2 + HALF_Q30) >> 30;
      term = term / TAYLOR_DIV[k];
      if (k[0] == 1'b0) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // Unsaturated magnitude of sin(step * m) in Q15, step in Q60 radians.
  function automatic logic [MAG_W-1:0] quarter_mag(input longint unsigned m,
                                                   input longint unsigned step);
    longint unsigned theta;
    longint unsigned s;
    theta = (step * m + HALF_Q30) >> 30;
    s     = sin_q30(theta);
    return MAG_W'((s + HALF_Q15) >> 15);
  endfunction

endpackage

// File: hdl/atq_sine_lut.sv
module atq_sine_lut #(
  parameter int TABLE_SIZE = atq_pkg::TABLE_SIZE_DEF
) (
  input  logic [$clog2(TABLE_SIZE):0]            idx,
  output logic signed [atq_pkg::SIN_W-1:0]       sine
);
  import atq_pkg::*;

  localparam int IW      = $clog2(TABLE_SIZE);
  localparam int QUARTER = TABLE_SIZE / 4;
  localparam int MW      = IW - 1;
  localparam longint unsigned STEP = TWO_PI_Q60 / 64'(TABLE_SIZE);

  // Quarter-wave magnitudes; the other three quadrants follow by symmetry.
  logic [MAG_W-1:0] mag_tab [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
    localparam logic [MAG_W-1:0] MAG = quarter_mag(longint'(g), STEP);
    assign mag_tab[g] = MAG;
  end

  logic [1:0]              quad;
  logic [IW-3:0]           pos;
  logic [MW-1:0]           mag_idx;
  logic [MAG_W-1:0]        mag;
  logic signed [MAG_W:0]   mag_neg;

  always_comb begin
    quad    = idx[IW-1:IW-2];
    pos     = idx[IW-3:0];
    mag_idx = quad[0] ? (MW'(QUARTER) - {1'b0, pos}) : {1'b0, pos};
    mag     = mag_tab[mag_idx];
    mag_neg = -$signed({1'b0, mag});
    if (quad[1]) begin
      sine = mag_neg[SIN_W-1:0];
    end else if (mag > MAG_SAT) begin
      sine = SIN_MAX;
    end else begin
      sine = $signed(mag[SIN_W-1:0]);
    end
  end

endmodule

// File: hdl/atq_bisect_cell.sv
module atq_bisect_cell #(
  parameter int TABLE_SIZE = atq_pkg::TABLE_SIZE_DEF,
  parameter int LEVEL      = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic signed [atq_pkg::COORD_W-1:0]    up_x,
  input  logic signed [atq_pkg::COORD_W-1:0]    up_y,
  input  logic [$clog2(TABLE_SIZE)-1:0]         up_lo,
  input  logic                                  up_sp,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic signed [atq_pkg::COORD_W-1:0]    dn_x,
  output logic signed [atq_pkg::COORD_W-1:0]    dn_y,
  output logic [$clog2(TABLE_SIZE)-1:0]         dn_lo,
  output logic                                  dn_sp
);
  import atq_pkg::*;

  localparam int IW        = $clog2(TABLE_SIZE);
  localparam int QUARTER   = TABLE_SIZE / 4;
  localparam int HALF_SPAN = QUARTER >> (LEVEL + 1);

  // Stage 1: midpoint and its sine and cosine.
  logic [IW-1:0]            mid_nxt;
  logic [IW-1:0]            cos_pos;
  logic signed [SIN_W-1:0]  sin_nxt;
  logic signed [SIN_W-1:0]  cos_nxt;

  logic                     v1_r, v2_r, v3_r;
  logic                     rdy1, rdy2, rdy3;
  logic signed [COORD_W-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [IW-1:0]            lo1_r, mid1_r, lo2_r, mid2_r, lo3_r;
  logic                     sp1_r, sp2_r, sp3_r;
  logic signed [SIN_W-1:0]  sin1_r, cos1_r;
  logic signed [PROD_W-1:0] ps_nxt, pc_nxt, ps2_r, pc2_r;
  logic signed [D_W-1:0]    cross_nxt;

  assign mid_nxt = up_lo + IW'(HALF_SPAN);
  assign cos_pos = mid_nxt + IW'(QUARTER);

  atq_sine_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sin (
    .idx  ({1'b0, mid_nxt}),
    .sine (sin_nxt)
  );

  atq_sine_lut #(.TABLE_SIZE(TABLE_SIZE)) u_cos (
    .idx  ({1'b0, cos_pos}),
    .sine (cos_nxt)
  );

  assign ps_nxt    = PROD_W'(x1_r) * PROD_W'(sin1_r);
  assign pc_nxt    = PROD_W'(y1_r) * PROD_W'(cos1_r);
  assign cross_nxt = D_W'(ps2_r) - D_W'(pc2_r);

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r   <= up_x;
      y1_r   <= up_y;
      lo1_r  <= up_lo;
      mid1_r <= mid_nxt;
      sp1_r  <= up_sp;
      sin1_r <= sin_nxt;
      cos1_r <= cos_nxt;
    end
    if (rdy2) begin
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      lo2_r  <= lo1_r;
      mid2_r <= mid1_r;
      sp2_r  <= sp1_r;
      ps2_r  <= ps_nxt;
      pc2_r  <= pc_nxt;
    end
    if (rdy3) begin
      x3_r  <= x2_r;
      y3_r  <= y2_r;
      sp3_r <= sp2_r;
      // A positive cross product means the angle lies below the midpoint.
      lo3_r <= (cross_nxt > 0) ? lo2_r : mid2_r;
    end
  end

  assign dn_valid = v3_r;
  assign dn_x     = x3_r;
  assign dn_y     = y3_r;
  assign dn_lo    = lo3_r;
  assign dn_sp    = sp3_r;

endmodule

// File: hdl/atq_edge_cell.sv
module atq_edge_cell #(
  parameter int TABLE_SIZE = atq_pkg::TABLE_SIZE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic signed [atq_pkg::COORD_W-1:0]    up_x,
  input  logic signed [atq_pkg::COORD_W-1:0]    up_y,
  input  logic [$clog2(TABLE_SIZE)-1:0]         up_lo,
  input  logic                                  up_sp,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic signed [atq_pkg::COORD_W-1:0]    dn_y,
  output logic [$clog2(TABLE_SIZE)-1:0]         dn_lo,
  output logic                                  dn_sp,
  output logic [atq_pkg::R_W-1:0]               dn_num,
  output logic [atq_pkg::R_W-1:0]               dn_den
);
  import atq_pkg::*;

  localparam int IW      = $clog2(TABLE_SIZE);
  localparam int QUARTER = TABLE_SIZE / 4;

  logic [IW:0]              lo_s, hi_s;
  logic [IW-1:0]            lo_c, hi_c;
  logic signed [SIN_W-1:0]  sl_nxt, cl_nxt, sh_nxt, ch_nxt;
  logic signed [SIN_W-1:0]  sl1_r, cl1_r, sh1_r, ch1_r;
  logic signed [PROD_W-1:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt;
  logic signed [PROD_W-1:0] pa2_r, pb2_r, pc2_r, pd2_r;
  logic signed [D_W-1:0]    dlo_nxt, dhi_nxt;
  logic signed [D_W:0]      num_nxt, den_nxt;
  logic                     frac_ok;

  logic                     v1_r, v2_r, v3_r;
  logic                     rdy1, rdy2, rdy3;
  logic signed [COORD_W-1:0] x1_r, y1_r, y2_r, y3_r;
  logic [IW-1:0]            lo1_r, lo2_r, lo3_r;
  logic                     sp1_r, sp2_r, sp3_r;
  logic [R_W-1:0]           num3_r, den3_r;

  // Both ends of the final pair; the upper sine index may reach a full turn.
  assign lo_s = {1'b0, up_lo};
  assign hi_s = lo_s + (IW+1)'(1);
  assign lo_c = up_lo + IW'(QUARTER);
  assign hi_c = up_lo + IW'(QUARTER + 1);

  atq_sine_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sl (.idx(lo_s),         .sine(sl_nxt));
  atq_sine_lut #(.TABLE_SIZE(TABLE_SIZE)) u_cl (.idx({1'b0, lo_c}), .sine(cl_nxt));
  atq_sine_lut #(.TABLE_SIZE(TABLE_SIZE)) u_sh (.idx(hi_s),         .sine(sh_nxt));
  atq_sine_lut #(.TABLE_SIZE(TABLE_SIZE)) u_ch (.idx({1'b0, hi_c}), .sine(ch_nxt));

  assign pa_nxt  = PROD_W'(x1_r) * PROD_W'(sl1_r);
  assign pb_nxt  = PROD_W'(y1_r) * PROD_W'(cl1_r);
  assign pc_nxt  = PROD_W'(x1_r) * PROD_W'(sh1_r);
  assign pd_nxt  = PROD_W'(y1_r) * PROD_W'(ch1_r);

  assign dlo_nxt = D_W'(pa2_r) - D_W'(pb2_r);
  assign dhi_nxt = D_W'(pc2_r) - D_W'(pd2_r);
  assign num_nxt = -(D_W+1)'(dlo_nxt);
  assign den_nxt = (D_W+1)'(dhi_nxt) - (D_W+1)'(dlo_nxt);
  // Without a positive numerator and divisor the fraction is zero; a zero
  // numerator over a unit divisor gives exactly that in the divider.
  assign frac_ok = (num_nxt > 0) && (den_nxt > 0);

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r  <= up_x;
      y1_r  <= up_y;
      lo1_r <= up_lo;
      sp1_r <= up_sp;
      sl1_r <= sl_nxt;
      cl1_r <= cl_nxt;
      sh1_r <= sh_nxt;
      ch1_r <= ch_nxt;
    end
    if (rdy2) begin
      y2_r  <= y1_r;
      lo2_r <= lo1_r;
      sp2_r <= sp1_r;
      pa2_r <= pa_nxt;
      pb2_r <= pb_nxt;
      pc2_r <= pc_nxt;
      pd2_r <= pd_nxt;
    end
    if (rdy3) begin
      y3_r   <= y2_r;
      lo3_r  <= lo2_r;
      sp3_r  <= sp2_r;
      num3_r <= frac_ok ? R_W'(num_nxt) : '0;
      den3_r <= frac_ok ? R_W'(den_nxt) : R_W'(1);
    end
  end

  assign dn_valid = v3_r;
  assign dn_y     = y3_r;
  assign dn_lo    = lo3_r;
  assign dn_sp    = sp3_r;
  assign dn_num   = num3_r;
  assign dn_den   = den3_r;

endmodule

// File: hdl/atq_div_cell.sv
module atq_div_cell #(
  parameter int TABLE_SIZE = atq_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_SHIFT = atq_pkg::FRAC_SHIFT_DEF,
  parameter int BIT        = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic signed [atq_pkg::COORD_W-1:0]    up_y,
  input  logic [$clog2(TABLE_SIZE)-1:0]         up_lo,
  input  logic                                  up_sp,
  input  logic [atq_pkg::R_W-1:0]               up_rem,
  input  logic [atq_pkg::R_W-1:0]               up_den,
  input  logic [FRAC_SHIFT:0]                   up_q,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic signed [atq_pkg::COORD_W-1:0]    dn_y,
  output logic [$clog2(TABLE_SIZE)-1:0]         dn_lo,
  output logic                                  dn_sp,
  output logic [atq_pkg::R_W-1:0]               dn_rem,
  output logic [atq_pkg::R_W-1:0]               dn_den,
  output logic [FRAC_SHIFT:0]                   dn_q
);
  import atq_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int QW = FRAC_SHIFT + 1;

  logic [R_W-1:0]           rem_sh;
  logic                     take;
  logic                     v_r;
  logic                     rdy;
  logic signed [COORD_W-1:0] y_r;
  logic [IW-1:0]            lo_r;
  logic                     sp_r;
  logic [R_W-1:0]           rem_r, den_r;
  logic [QW-1:0]            q_r;

  // The top quotient bit compares the numerator as it stands; every later
  // bit doubles the partial remainder first.
  assign rem_sh   = (BIT == FRAC_SHIFT) ? up_rem : {up_rem[R_W-2:0], 1'b0};
  assign take     = rem_sh >= up_den;
  assign rdy      = !v_r || dn_ready;
  assign up_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      y_r   <= up_y;
      lo_r  <= up_lo;
      sp_r  <= up_sp;
      den_r <= up_den;
      rem_r <= take ? (rem_sh - up_den) : rem_sh;
      q_r   <= up_q | (QW'(take) << BIT);
    end
  end

  assign dn_valid = v_r;
  assign dn_y     = y_r;
  assign dn_lo    = lo_r;
  assign dn_sp    = sp_r;
  assign dn_rem   = rem_r;
  assign dn_den   = den_r;
  assign dn_q     = q_r;

endmodule

// File: hdl/atan2_q15_table_bisection_unit.sv
// Channel   Direction  tdata (lowest bit up)                 Transfer
// in_       slave      y_value[15:0], x_value[31:16]         in_tvalid & in_tready
// out_      master     angle[14:0], zero[15]                 out_tvalid & out_tready
//
// One transfer in is taken every cycle when the chain is not blocked; each result
// passes through the entry register, three registers per bisection cell, three in
// the end-point cell, one per quotient bit of the divider chain and the output register.
// Reset clears only the valid bits; the sine table is constant logic and needs no fill.
// A stalled output holds its result while earlier stages close up bubbles behind it.
module atan2_q15_table_bisection_unit #(
  parameter int TABLE_SIZE = atq_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_SHIFT = atq_pkg::FRAC_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // y_value[15:0], x_value[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // angle[14:0], zero pad [15]
);
  import atq_pkg::*;

  localparam int IW      = $clog2(TABLE_SIZE);
  localparam int QUARTER = TABLE_SIZE / 4;
  localparam int NB      = IW - 2;          // bisection cells
  localparam int QW      = FRAC_SHIFT + 1;  // quotient bits, fraction never exceeds one entry
  localparam int SUM_W   = (IW + FRAC_SHIFT + 1 > ANGLE_W) ? IW + FRAC_SHIFT + 1 : ANGLE_W;
  localparam logic [QW-1:0] Q_MAX = QW'(1) << FRAC_SHIFT;

  // Input split.
  logic signed [COORD_W-1:0] in_y, in_x;
  assign in_y = $signed(in_tdata[15:0]);
  assign in_x = $signed(in_tdata[31:16]);

  // Entry stage: picks the quadrant span and flags a zero x, whose search result is
  // replaced at the output by an angle resolved from the sign of y.
  logic                      v0_r;
  logic signed [COORD_W-1:0] x0_r, y0_r;
  logic [IW-1:0]             lo0_r, lo0_nxt;
  logic                      sp0_r;
  logic                      rdy0;

  always_comb begin
    if (in_x > 0) begin
      lo0_nxt = (in_y >= 0) ? '0 : IW'(3 * QUARTER);
    end else begin
      lo0_nxt = (in_y >= 0) ? IW'(QUARTER) : IW'(2 * QUARTER);
    end
  end

  // Bisection chain: element e is produced by the entry stage (e = 0) or by
  // bisection cell e-1; erdy[e] is the ready its consumer returns.
  logic                      ev   [NB+1];
  logic                      erdy [NB+1];
  logic signed [COORD_W-1:0] ex   [NB+1];
  logic signed [COORD_W-1:0] ey   [NB+1];
  logic [IW-1:0]             elo  [NB+1];
  logic                      esp  [NB+1];

  assign rdy0      = !v0_r || erdy[0];
  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      x0_r  <= in_x;
      y0_r  <= in_y;
      lo0_r <= lo0_nxt;
      sp0_r <= (in_x == 0);
    end
  end

  assign ev[0]  = v0_r;
  assign ex[0]  = x0_r;
  assign ey[0]  = y0_r;
  assign elo[0] = lo0_r;
  assign esp[0] = sp0_r;

  for (genvar c = 0; c < NB; c++) begin : g_bisect
    atq_bisect_cell #(
      .TABLE_SIZE (TABLE_SIZE),
      .LEVEL      (c)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ev[c]),
      .up_ready (erdy[c]),
      .up_x     (ex[c]),
      .up_y     (ey[c]),
      .up_lo    (elo[c]),
      .up_sp    (esp[c]),
      .dn_valid (ev[c+1]),
      .dn_ready (erdy[c+1]),
      .dn_x     (ex[c+1]),
      .dn_y     (ey[c+1]),
      .dn_lo    (elo[c+1]),
      .dn_sp    (esp[c+1])
    );
  end

  // Divider chain: element 0 comes from the end-point cell, element f from
  // quotient cell f-1, most significant quotient bit first.
  logic                      fv   [QW+1];
  logic                      frdy [QW+1];
  logic signed [COORD_W-1:0] fy   [QW+1];
  logic [IW-1:0]             flo  [QW+1];
  logic                      fsp  [QW+1];
  logic [R_W-1:0]            frem [QW+1];
  logic [R_W-1:0]            fden [QW+1];
  logic [QW-1:0]             fq   [QW+1];

  atq_edge_cell #(.TABLE_SIZE(TABLE_SIZE)) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ev[NB]),
    .up_ready (erdy[NB]),
    .up_x     (ex[NB]),
    .up_y     (ey[NB]),
    .up_lo    (elo[NB]),
    .up_sp    (esp[NB]),
    .dn_valid (fv[0]),
    .dn_ready (frdy[0]),
    .dn_y     (fy[0]),
    .dn_lo    (flo[0]),
    .dn_sp    (fsp[0]),
    .dn_num   (frem[0]),
    .dn_den   (fden[0])
  );

  assign fq[0] = '0;

  for (genvar f = 0; f < QW; f++) begin : g_div
    atq_div_cell #(
      .TABLE_SIZE (TABLE_SIZE),
      .FRAC_SHIFT (FRAC_SHIFT),
      .BIT        (FRAC_SHIFT - f)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (fv[f]),
      .up_ready (frdy[f]),
      .up_y     (fy[f]),
      .up_lo    (flo[f]),
      .up_sp    (fsp[f]),
      .up_rem   (frem[f]),
      .up_den   (fden[f]),
      .up_q     (fq[f]),
      .dn_valid (fv[f+1]),
      .dn_ready (frdy[f+1]),
      .dn_y     (fy[f+1]),
      .dn_lo    (flo[f+1]),
      .dn_sp    (fsp[f+1]),
      .dn_rem   (frem[f+1]),
      .dn_den   (fden[f+1]),
      .dn_q     (fq[f+1])
    );
  end

  // Output register: base index plus fraction, wrapped to 15 bits so that a
  // full turn reads as zero.
  logic                 out_valid_r;
  logic [ANGLE_W-1:0]   angle_r, angle_nxt;
  logic [SUM_W-1:0]     sum_full;
  logic                 rdy_o;

  assign sum_full = (SUM_W'(flo[QW]) << FRAC_SHIFT) + SUM_W'(fq[QW]);

  always_comb begin
    if (!fsp[QW]) begin
      angle_nxt = sum_full[ANGLE_W-1:0];
    end else if (fy[QW] > 0) begin
      angle_nxt = ANG_QUARTER;
    end else if (fy[QW] < 0) begin
      angle_nxt = ANG_THREE_Q;
    end else begin
      angle_nxt = '0;
    end
  end

  assign rdy_o    = !out_valid_r || out_tready;
  assign frdy[QW] = rdy_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_o) begin
      out_valid_r <= fv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, angle_r};

`ifndef SYNTHESIS
  // With the output register empty nothing downstream can hold the chain.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the output register is empty");

  // The bracketing pair keeps the lower cross product at or below zero and
  // the upper at or above it, so the numerator never exceeds the divisor.
  a_num_le_den : assert property (@(posedge clk) disable iff (!rst_n)
    fv[0] |-> (frem[0] <= fden[0]))
    else $error("interpolation numerator exceeds its divisor");

  // Hence the fraction is at most one whole table entry.
  a_frac_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (fv[QW] && !fsp[QW]) |-> (fq[QW] <= Q_MAX))
    else $error("interpolated fraction exceeds one table entry");
`endif

endmodule
